// ----- design/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types, codes and the ordering rule of the sorted task queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

	localparam int IdW    = 16;
	localparam int PrioW  = 8;
	localparam int TimeW  = 16;
	localparam int BatchW = 7;
	localparam int StatW  = 2;
	localparam int OccW   = 7;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} ptq_op_t;

	localparam logic [StatW-1:0] ST_OK    = 2'd0;
	localparam logic [StatW-1:0] ST_FULL  = 2'd1;
	localparam logic [StatW-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic [TimeW-1:0] etime;
	} ptq_entry_t;

	typedef enum logic [1:0] {
		RES_INSERT,
		RES_FULL,
		RES_EMPTY,
		RES_POP
	} ptq_res_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_DONE
	} ptq_state_t;

	// controller to datapath
	typedef struct packed {
		logic          load_key;
		logic          ins_step;
		logic          pop;
		logic          res_load;
		ptq_res_kind_t res_kind;
	} ptq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic fits;
		logic zero_batch;
		logic last;
	} ptq_sts_t;

	// held entry stays ahead of a new task with key (p, t)
	function automatic logic ptq_goes_ahead(ptq_entry_t e, logic [PrioW-1:0] p,
			logic [TimeW-1:0] t);
		if (e.prio != p) begin
			return e.prio > p;
		end
		return e.etime <= t;
	endfunction

endpackage

// ----- design/ptq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptq_ctrl
// Controller: accepts words, sequences batch inserts, owns the result valid.
// ----------------------------------------------------------------------------
module ptq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              opcode,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  ptq_pkg::ptq_sts_t sts,
	output ptq_pkg::ptq_cmd_t cmd
);
	import ptq_pkg::*;

	ptq_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       take;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_kind = RES_INSERT;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (opcode == OP_EXTRACT) begin
						cmd.res_load = 1'b1;
						if (sts.empty) begin
							cmd.res_kind = RES_EMPTY;
						end else begin
							cmd.res_kind = RES_POP;
							cmd.pop      = 1'b1;
						end
					end else if (!sts.fits) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_FULL;
					end else if (sts.zero_batch) begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_INSERT;
					end else begin
						cmd.load_key = 1'b1;
						state_d      = S_INSERT;
					end
				end
			end
			S_INSERT: begin
				cmd.ins_step = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register can take the word
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_INSERT;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.res_load)
		else $error("pending result overwritten");

	a_last_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSERT && sts.last) |=> (state_q == S_DONE))
		else $error("batch end not followed by result stage");

	a_step_in_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_step |-> !take)
		else $error("word accepted during batch insert");

endmodule

// ----- design/ptq_store.sv -----
// ----------------------------------------------------------------------------
// ptq_store
// Datapath: row of sorted cells, task count, batch key and result register.
// ----------------------------------------------------------------------------
module ptq_store #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ptq_pkg::IdW-1:0]     base_id,
	input  logic [ptq_pkg::BatchW-1:0]  batch_count,
	input  logic [ptq_pkg::PrioW-1:0]   priority_req,
	input  logic [ptq_pkg::TimeW-1:0]   exec_time,
	input  ptq_pkg::ptq_cmd_t           cmd,
	output ptq_pkg::ptq_sts_t           sts,
	output logic [ptq_pkg::StatW-1:0]   status,
	output logic [ptq_pkg::IdW-1:0]     out_task_id,
	output logic [ptq_pkg::PrioW-1:0]   out_priority,
	output logic [ptq_pkg::TimeW-1:0]   out_exec_time,
	output logic [ptq_pkg::OccW-1:0]    occupancy
);
	import ptq_pkg::*;

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam int SumW = ((CntW > BatchW) ? CntW : BatchW) + 1;

	ptq_entry_t          cell_q [QUEUE_DEPTH];
	ptq_entry_t          cell_d [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ahead;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     count_dec;
	logic [PrioW-1:0]    key_prio_q;
	logic [TimeW-1:0]    key_time_q;
	logic [IdW-1:0]      id_q;
	logic [BatchW-1:0]   rem_q;
	logic [SumW-1:0]     fill_sum;
	logic [CntW+OccW-1:0] occ_now;
	logic [CntW+OccW-1:0] occ_pop;
	ptq_entry_t          new_entry;

	assign count_dec  = count_q - CntW'(1);
	assign occ_now    = (CntW+OccW)'(count_q);
	assign occ_pop    = (CntW+OccW)'(count_dec);
	assign fill_sum   = SumW'(count_q) + SumW'(batch_count);

	assign sts.empty      = (count_q == '0);
	assign sts.fits       = (fill_sum <= SumW'(QUEUE_DEPTH));
	assign sts.zero_batch = (batch_count == '0);
	assign sts.last       = (rem_q == BatchW'(1));

	assign new_entry.id    = id_q;
	assign new_entry.prio  = key_prio_q;
	assign new_entry.etime = key_time_q;

	// each cell compares itself against the batch key
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ahead[i] = (CntW'(i) < count_q)
				&& ptq_goes_ahead(cell_q[i], key_prio_q, key_time_q);
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_d[i] = cell_q[i];
		end
		if (cmd.ins_step) begin
			// keep, take the new task, or shift down from the left neighbor
			if (!ahead[0]) begin
				cell_d[0] = new_entry;
			end
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (!ahead[i]) begin
					cell_d[i] = ahead[i-1] ? new_entry : cell_q[i-1];
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				cell_d[i] = cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			cell_q[i] <= cell_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_step) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.pop) begin
			count_q <= count_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.load_key) begin
			rem_q <= batch_count;
		end else if (cmd.ins_step) begin
			rem_q <= rem_q - BatchW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_prio_q <= priority_req;
			key_time_q <= exec_time;
			id_q       <= base_id + IdW'(1);
		end else if (cmd.ins_step) begin
			id_q <= id_q + IdW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_task_id   <= '0;
			out_priority  <= '0;
			out_exec_time <= '0;
			occupancy     <= occ_now[OccW-1:0];
			case (cmd.res_kind)
				RES_INSERT: status <= ST_OK;
				RES_FULL:   status <= ST_FULL;
				RES_EMPTY:  status <= ST_EMPTY;
				RES_POP: begin
					status        <= ST_OK;
					out_task_id   <= cell_q[0].id;
					out_priority  <= cell_q[0].prio;
					out_exec_time <= cell_q[0].etime;
					occupancy     <= occ_pop[OccW-1:0];
				end
				default: status <= ST_OK;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("task count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop from empty queue");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_step |-> (count_q < CntW'(QUEUE_DEPTH)))
		else $error("insert into full queue");

endmodule

// ----- design/priority_time_sorted_task_queue_core.sv -----
// ----------------------------------------------------------------------------
// priority_time_sorted_task_queue_core
// Sorted task queue: batch insert by priority and time, head extract.
// ----------------------------------------------------------------------------
// Holds up to QUEUE_DEPTH tasks in a row of register cells kept sorted by
// priority (high first), then execution time (short first), then arrival.
// Every word in gives exactly one word out. An extract, a refused batch or an
// empty batch is answered as the word is taken. A batch of n tasks loads the
// batch key, then the cell row does one ordered insert per cycle, every cell
// comparing itself to the batch key in parallel and either holding, taking the
// new task or shifting down; the result word is loaded once the output register
// is free. A finished word waits in the output register; a new word is accepted
// only while that register is empty or being read in the same cycle, so s_tready
// follows m_tready combinationally. No clearing pass runs after reset.
module priority_time_sorted_task_queue_core #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// base_id[15:0], batch_count[22:16], priority_req[30:23],
	// exec_time[46:31], zero[47]
	input  logic [47:0] s_tdata,
	// opcode[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_task_id[15:0], out_priority[23:16], out_exec_time[39:24],
	// occupancy[46:40], zero[47]
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	import ptq_pkg::*;

	ptq_cmd_t           cmd;
	ptq_sts_t           sts;
	logic [IdW-1:0]     out_task_id;
	logic [PrioW-1:0]   out_priority;
	logic [TimeW-1:0]   out_exec_time;
	logic [OccW-1:0]    occupancy;
	logic [StatW-1:0]   status;

	ptq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptq_store #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_id       (s_tdata[15:0]),
		.batch_count   (s_tdata[22:16]),
		.priority_req  (s_tdata[30:23]),
		.exec_time     (s_tdata[46:31]),
		.cmd           (cmd),
		.sts           (sts),
		.status        (status),
		.out_task_id   (out_task_id),
		.out_priority  (out_priority),
		.out_exec_time (out_exec_time),
		.occupancy     (occupancy)
	);

	assign m_tdata = {1'b0, occupancy, out_exec_time, out_priority, out_task_id};
	assign m_tuser = status;

endmodule

// ----- sim/ptq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptq_checker
// Watches both streams of the sorted task queue and checks every result word.
// ----------------------------------------------------------------------------
// Keeps its own sorted copy of the held tasks, works out the result of each
// accepted input word and compares it, field by field, with the oldest result
// still owed when a result word is accepted.
module ptq_checker #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          mismatches,
	output int          pending,
	output int          results_seen,
	output int          refused_batches,
	output int          empty_pulls,
	output int          peak_fill
);
	import ptq_pkg::*;

	typedef struct packed {
		logic [StatW-1:0] status;
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic [TimeW-1:0] etime;
		logic [OccW-1:0]  occ;
	} queue_result_t;

	ptq_entry_t    held_tasks[$];
	queue_result_t owed_results[$];

	// apply one input word to the sorted copy and return its result word
	function automatic queue_result_t serve_word(ptq_op_t op, logic [IdW-1:0] base,
			logic [BatchW-1:0] cnt, logic [PrioW-1:0] p, logic [TimeW-1:0] t);
		queue_result_t r;
		ptq_entry_t    e;
		int            pos;
		r = '0;
		r.status = ST_OK;
		if (op == OP_INSERT) begin
			if (held_tasks.size() + int'(cnt) > QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// skip every held task with an equal or better key
				pos = 0;
				while (pos < held_tasks.size() && (held_tasks[pos].prio > p ||
						(held_tasks[pos].prio == p && held_tasks[pos].etime <= t))) begin
					pos++;
				end
				for (int i = 0; i < int'(cnt); i++) begin
					e.id    = base + IdW'(i + 1);
					e.prio  = p;
					e.etime = t;
					held_tasks.insert(pos + i, e);
				end
			end
		end else if (held_tasks.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			e = held_tasks.pop_front();
			r.id    = e.id;
			r.prio  = e.prio;
			r.etime = e.etime;
		end
		r.occ = OccW'(held_tasks.size());
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		queue_result_t got;
		if (arst_n) begin
			// a result word never belongs to the input word taken at the same edge
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[15:0], m_tdata[23:16], m_tdata[39:24], m_tdata[46:40]};
				results_seen++;
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected, actual %h", $time, got);
				end else begin
					want = owed_results.pop_front();
					check_field("status", want.status, got.status);
					check_field("task id", want.id, got.id);
					check_field("priority", want.prio, got.prio);
					check_field("exec time", want.etime, got.etime);
					check_field("occupancy", want.occ, got.occ);
				end
			end
			if (s_tvalid && s_tready) begin
				want = serve_word(ptq_op_t'(s_tuser[0]), s_tdata[15:0], s_tdata[22:16],
					s_tdata[30:23], s_tdata[46:31]);
				if (want.status == ST_FULL) begin
					refused_batches++;
				end
				if (want.status == ST_EMPTY) begin
					empty_pulls++;
				end
				if (int'(want.occ) > peak_fill) begin
					peak_fill = int'(want.occ);
				end
				owed_results.push_back(want);
			end
			pending <= owed_results.size();
		end
	end

endmodule

// ----- sim/tb_priority_time_sorted_task_queue_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_time_sorted_task_queue_core
// Stimulus and verdict for the sorted task queue core.
// ----------------------------------------------------------------------------
// Runs a short directed sequence over the ordering rules, id wrap, full and
// empty cases, then blocks of random words that alternately fill and drain
// the queue. Both sides idle at random, with one calm block, one long receiver
// hold-off and sender pauses until all results are back. Checking is done by
// ptq_checker.
module tb_priority_time_sorted_task_queue_core;
	import ptq_pkg::*;

	localparam int QDEPTH       = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 70;
	localparam int BLOCKS       = 12;
	localparam int BLOCK_WORDS  = 96;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// base_id, batch_count, priority_req, exec_time, zero
	logic [47:0] s_tdata  = '0;
	// opcode
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// out_task_id, out_priority, out_exec_time, occupancy, zero
	logic [47:0] m_tdata;
	// status
	logic [1:0]  m_tuser;

	int mismatches;
	int pending;
	int results_seen;
	int refused_batches;
	int empty_pulls;
	int peak_fill;
	int words_sent;
	bit calm;
	bit hold_req;
	// percent of extracts per random block: low fills, high drains
	int extract_mix[BLOCKS] = '{40, 92, 60, 95, 30, 90, 85, 97, 45, 93, 75, 96};

	priority_time_sorted_task_queue_core #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	ptq_checker #(
		.QUEUE_DEPTH(QDEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.refused_batches(refused_batches),
		.empty_pulls(empty_pulls),
		.peak_fill(peak_fill)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 38);
			end
		end
	end

	task automatic send_word(ptq_op_t op, logic [IdW-1:0] base, logic [BatchW-1:0] cnt,
			logic [PrioW-1:0] prio, logic [TimeW-1:0] etime);
		while (!calm && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, etime, prio, cnt, base};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic random_word(int extract_pct);
		ptq_op_t           op;
		logic [BatchW-1:0] cnt;
		logic [PrioW-1:0]  prio;
		logic [TimeW-1:0]  etime;
		int                pick;
		op = ($urandom_range(99) < extract_pct) ? OP_EXTRACT : OP_INSERT;
		// mostly small batches, now and then a large one
		pick = $urandom_range(99);
		if (pick < 8) begin
			cnt = '0;
		end else if (pick < 75) begin
			cnt = BatchW'($urandom_range(4, 1));
		end else if (pick < 93) begin
			cnt = BatchW'($urandom_range(16, 5));
		end else begin
			cnt = BatchW'($urandom_range(QDEPTH, 17));
		end
		// few distinct keys half the time, so ties are common
		if ($urandom_range(1)) begin
			prio  = PrioW'($urandom_range(3) * 85);
			etime = TimeW'($urandom_range(3) * 21845);
		end else begin
			prio  = PrioW'($urandom_range(255));
			etime = TimeW'($urandom_range(65535));
		end
		send_word(op, IdW'($urandom_range(65535)), cnt, prio, etime);
	endtask

	// drop valid and wait for every owed result
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_EXTRACT, 16'hFFFF, 7'd64, 8'hFF, 16'hFFFF);
		send_word(OP_INSERT, 16'hFFFF, 7'd0, 8'hFF, 16'h0000);
		// ids wrap through zero
		send_word(OP_INSERT, 16'hFFFE, 7'd3, 8'h80, 16'd100);
		send_word(OP_INSERT, 16'h0100, 7'd2, 8'h80, 16'd50);
		send_word(OP_INSERT, 16'h0200, 7'd2, 8'h80, 16'd100);
		send_word(OP_INSERT, 16'h0300, 7'd1, 8'hFF, 16'hFFFF);
		send_word(OP_INSERT, 16'h0400, 7'd1, 8'h00, 16'h0000);
		send_word(OP_INSERT, 16'h0500, 7'd1, 8'h80, 16'h0000);
		send_word(OP_INSERT, 16'h0600, 7'd64, 8'h7F, 16'h1234);
		// fill to exactly the depth, then overflow by one
		send_word(OP_INSERT, 16'h0700, 7'd54, 8'h7F, 16'hFFFF);
		send_word(OP_INSERT, 16'h0800, 7'd1, 8'hFF, 16'h0000);
		send_word(OP_INSERT, 16'h0900, 7'd0, 8'h01, 16'h8000);
		repeat (10) send_word(OP_EXTRACT, 16'h5A5A, 7'd42, 8'h55, 16'hA5A5);
		send_word(OP_INSERT, 16'hFFC0, 7'd10, 8'hFF, 16'h0000);
		repeat (2) send_word(OP_EXTRACT, 16'h0000, 7'd0, 8'h00, 16'h0000);
		wait_idle();

		for (int blk = 0; blk < BLOCKS; blk++) begin
			calm = (blk == 3);
			if (blk == 4) begin
				hold_req = 1'b1;
			end
			for (int j = 0; j < BLOCK_WORDS; j++) begin
				random_word(extract_mix[blk]);
			end
			if (blk == 8) begin
				wait_idle();
			end
		end
		calm = 1'b0;

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d words sent, %0d results checked, %0d batches refused, %s",
			words_sent, results_seen, refused_batches,
			$sformatf("%0d empty extracts", empty_pulls));
		$display("summary: peak fill %0d of %0d tasks, one receiver hold-off of %0d cycles",
			peak_fill, QDEPTH, HOLD_CYCLES);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/ptq_pkg.sv
design/ptq_ctrl.sv
design/ptq_store.sv
design/priority_time_sorted_task_queue_core.sv
sim/ptq_checker.sv
sim/tb_priority_time_sorted_task_queue_core.sv
